### rtl/cfm_pkg.sv
package cfm_pkg;

  localparam int unsigned CODE_SPACE = 65536;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned ENTRY_W    = CODE_W + TAG_W;
  localparam int unsigned ADDR_W     = $clog2(CODE_SPACE);

  // table size as a value comparable against a zero-extended code
  localparam logic [CODE_W:0] SPACE_LIM = (CODE_W + 1)'(CODE_SPACE);

  typedef enum logic [2:0] {
    CMD_MAP        = 3'd0,
    CMD_RANGE      = 3'd1,
    CMD_PASS       = 3'd2,
    CMD_RANGE_PASS = 3'd3,
    CMD_TRANSFORM  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEN   = 2'd1,
    ST_ORDER = 2'd2,
    ST_SKIP  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_WALK
  } ctrl_state_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    status_e              status;
    logic                 replaced;
    logic [CODE_W-1:0]    code;
    logic [TAG_W-1:0]     tag;
    logic                 tag_valid;
  } res_t;

endpackage

### rtl/cfm_table.sv
module cfm_table (
  input  logic                    clk_i,
  input  cfm_pkg::mem_req_t       req_i,
  output logic [cfm_pkg::ENTRY_W-1:0] rd_data_o
);
  import cfm_pkg::*;

  logic [ENTRY_W-1:0] mem [CODE_SPACE];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/cfm_ctrl.sv
module cfm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  command_i,
  input  logic [cfm_pkg::CODE_W-1:0]  src_code_i,
  input  logic [cfm_pkg::CODE_W-1:0]  src_last_i,
  input  logic [cfm_pkg::CODE_W-1:0]  dest_code_i,
  input  logic [cfm_pkg::CODE_W-1:0]  dest_last_i,
  input  logic [cfm_pkg::TAG_W-1:0]   tag_in_i,
  input  logic                        pass_thru_i,
  input  logic                        out_free_i,
  output logic                        res_push_o,
  output cfm_pkg::res_t               res_o,
  output cfm_pkg::mem_req_t           mem_req_o,
  input  logic [cfm_pkg::ENTRY_W-1:0] rd_data_i
);
  import cfm_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [ADDR_W-1:0]   clr_ptr_q, clr_ptr_d;
  logic                res_pend_q, res_pend_d;

  logic [CODE_W-1:0]   ptr_q, ptr_d;
  logic [CODE_W-1:0]   last_q, last_d;
  logic [CODE_W-1:0]   dst_q, dst_d;
  logic [TAG_W-1:0]    tag_q, tag_d;
  logic                xform_q, xform_d;
  logic                repl_q, repl_d;
  res_t                res_q, res_d;

  logic                in_accept;
  logic                push;
  logic                is_range, is_pass;
  logic                order_err, len_err, skip;
  logic                ptr_in_range;
  logic [ENTRY_W-1:0]  entry;
  logic                entry_hit;
  logic [CODE_W-1:0]   ptr_inc;

  assign push       = res_pend_q && out_free_i;
  assign in_stall_o = !((state_q == CS_IDLE) && (!res_pend_q || out_free_i));
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_range  = (command_i == CMD_RANGE) || (command_i == CMD_RANGE_PASS);
  assign is_pass   = (command_i == CMD_PASS) || (command_i == CMD_RANGE_PASS);
  assign order_err = ((command_i == CMD_RANGE) &&
                      ((src_code_i >= src_last_i) || (dest_code_i >= dest_last_i))) ||
                     ((command_i == CMD_RANGE_PASS) && (src_code_i >= src_last_i));
  assign len_err   = (command_i == CMD_RANGE) &&
                     ((src_last_i - src_code_i) != (dest_last_i - dest_code_i));
  assign skip      = is_pass && pass_thru_i && (tag_in_i == '0);

  assign ptr_in_range = {1'b0, ptr_q} < SPACE_LIM;
  assign entry        = ptr_in_range ? rd_data_i : '0;
  assign entry_hit    = (entry != '0);
  assign ptr_inc      = ptr_q + CODE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CS_CLEAR;
      clr_ptr_q  <= '0;
      res_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_ptr_q  <= clr_ptr_d;
      res_pend_q <= res_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    last_q  <= last_d;
    dst_q   <= dst_d;
    tag_q   <= tag_d;
    xform_q <= xform_d;
    repl_q  <= repl_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_ptr_d  = clr_ptr_q;
    res_pend_d = res_pend_q && !push;
    ptr_d      = ptr_q;
    last_d     = last_q;
    dst_d      = dst_q;
    tag_d      = tag_q;
    xform_d    = xform_q;
    repl_d     = repl_q;
    res_d      = res_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = ptr_q[ADDR_W-1:0];
    mem_req_o.wdata = {tag_q, dst_q};
    mem_req_o.raddr = src_code_i[ADDR_W-1:0];

    case (state_q)
      CS_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_ptr_q;
        mem_req_o.wdata = '0;
        clr_ptr_d       = clr_ptr_q + ADDR_W'(1);
        if (clr_ptr_q == ADDR_W'(CODE_SPACE - 1)) begin
          state_d = CS_IDLE;
        end
      end

      CS_IDLE: begin
        if (in_accept) begin
          ptr_d   = src_code_i;
          last_d  = is_range ? src_last_i : src_code_i;
          dst_d   = is_pass ? src_code_i : dest_code_i;
          tag_d   = tag_in_i;
          xform_d = (command_i == CMD_TRANSFORM);
          repl_d  = 1'b0;
          res_d   = '0;
          res_d.status = ST_OK;
          case (command_i)
            CMD_MAP, CMD_TRANSFORM: begin
              state_d = CS_WALK;
            end
            CMD_RANGE: begin
              if (order_err) begin
                res_d.status = ST_ORDER;
                res_pend_d   = 1'b1;
              end else if (len_err) begin
                res_d.status = ST_LEN;
                res_pend_d   = 1'b1;
              end else begin
                state_d = CS_WALK;
              end
            end
            CMD_PASS: begin
              if (skip) begin
                res_d.status = ST_SKIP;
                res_pend_d   = 1'b1;
              end else begin
                state_d = CS_WALK;
              end
            end
            CMD_RANGE_PASS: begin
              if (order_err) begin
                res_d.status = ST_ORDER;
                res_pend_d   = 1'b1;
              end else if (skip) begin
                res_d.status = ST_SKIP;
                res_pend_d   = 1'b1;
              end else begin
                state_d = CS_WALK;
              end
            end
            default: begin
              // unknown command: no effect, plain ok beat
              res_pend_d = 1'b1;
            end
          endcase
        end
      end

      CS_WALK: begin
        // rd_data_i holds the entry at ptr_q, read in the cycle before
        if (xform_q) begin
          res_d.status    = ST_OK;
          res_d.replaced  = 1'b0;
          res_d.tag_valid = entry_hit;
          res_d.code      = entry_hit ? entry[CODE_W-1:0] :
                            (pass_thru_i ? ptr_q : '0);
          res_d.tag       = entry_hit ? entry[ENTRY_W-1:CODE_W] : '0;
          res_pend_d      = 1'b1;
          state_d         = CS_IDLE;
        end else begin
          mem_req_o.we    = ptr_in_range;
          repl_d          = repl_q || entry_hit;
          mem_req_o.raddr = ptr_inc[ADDR_W-1:0];
          if (ptr_q == last_q) begin
            res_d.status    = ST_OK;
            res_d.replaced  = repl_q || entry_hit;
            res_d.code      = '0;
            res_d.tag       = '0;
            res_d.tag_valid = 1'b0;
            res_pend_d      = 1'b1;
            state_d         = CS_IDLE;
          end else begin
            ptr_d = ptr_inc;
            dst_d = dst_q + CODE_W'(1);
          end
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign res_push_o = push;
  assign res_o      = res_q;

endmodule

### rtl/char_fold_map_table_core.sv
// Items that touch no entry (range errors, skip, unknown command) give their
//   result beat without a walk; other items walk N entries (N = 1 for
//   transform and single maps), then the result goes to the output register.
// Throughput: one table entry per cycle while walking; the input is stalled
//   during a walk and while a result waits for the output register.
// Reset: all 65536 table entries swept to zero, input stalled; pass_thru is 1.
module char_fold_map_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_pass_thru_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  command_i,
  input  logic [cfm_pkg::CODE_W-1:0]  src_code_i,
  input  logic [cfm_pkg::CODE_W-1:0]  src_last_i,
  input  logic [cfm_pkg::CODE_W-1:0]  dest_code_i,
  input  logic [cfm_pkg::CODE_W-1:0]  dest_last_i,
  input  logic [cfm_pkg::TAG_W-1:0]   tag_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        replaced_o,
  output logic [cfm_pkg::CODE_W-1:0]  code_out_o,
  output logic [cfm_pkg::TAG_W-1:0]   tag_out_o,
  output logic                        tag_valid_o
);
  import cfm_pkg::*;

  logic               pass_thru_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  logic               out_free;
  logic               res_push;
  res_t               res;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_thru_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pass_thru_q <= cfg_pass_thru_i;
    end
  end

  // output register: free when empty or its beat leaves this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  cfm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .src_code_i     (src_code_i),
    .src_last_i     (src_last_i),
    .dest_code_i    (dest_code_i),
    .dest_last_i    (dest_last_i),
    .tag_in_i       (tag_in_i),
    .pass_thru_i    (pass_thru_q),
    .out_free_i     (out_free),
    .res_push_o     (res_push),
    .res_o          (res),
    .mem_req_o      (mem_req),
    .rd_data_i      (rd_data)
  );

  cfm_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign replaced_o  = out_q.replaced;
  assign code_out_o  = out_q.code;
  assign tag_out_o   = out_q.tag;
  assign tag_valid_o = out_q.tag_valid;

endmodule

### rtl/cfm_checker.sv
module cfm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic                        replaced_o,
  input logic [cfm_pkg::CODE_W-1:0]  code_out_o,
  input logic [cfm_pkg::TAG_W-1:0]   tag_out_o,
  input logic                        tag_valid_o
);
  import cfm_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(replaced_o) && $stable(code_out_o) && $stable(tag_out_o) &&
      $stable(tag_valid_o))
    else $error("stalled result beat changed");

  // tag is only reported on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tag_valid_o |-> tag_out_o == '0)
    else $error("tag_out nonzero without tag_valid");

  // error and skip beats carry no lookup or write result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      code_out_o == '0 && !replaced_o && !tag_valid_o)
    else $error("error beat carries data");

  // a transform hit never reports a replacement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tag_valid_o |-> !replaced_o && status_o == ST_OK)
    else $error("hit beat flags replaced");

endmodule

bind char_fold_map_table_core cfm_checker u_cfm_checker (.*);

### verif/tb_char_fold_map_table_core.sv
`timescale 1ns / 100ps

module tb_char_fold_map_table_core;
  import cfm_pkg::*;

  typedef struct {
    logic [2:0]        command;
    logic [CODE_W-1:0] src_code;
    logic [CODE_W-1:0] src_last;
    logic [CODE_W-1:0] dest_code;
    logic [CODE_W-1:0] dest_last;
    logic [TAG_W-1:0]  tag_in;
  } fold_req_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  localparam logic [CODE_W-1:0] CODE_MAX    = '1;
  localparam int unsigned       WINDOW_SPAN = 128;
  localparam int unsigned       PHASES      = 8;
  localparam int unsigned       PHASE_ITEMS = 140;
  localparam int unsigned       MAX_REPORTS = 100;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              cfg_valid_i        = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_pass_thru_i    = 1'b1;
  logic              in_valid_i         = 1'b0;
  logic              in_stall_o;
  logic [2:0]        command_i          = '0;
  logic [CODE_W-1:0] src_code_i         = '0;
  logic [CODE_W-1:0] src_last_i         = '0;
  logic [CODE_W-1:0] dest_code_i        = '0;
  logic [CODE_W-1:0] dest_last_i        = '0;
  logic [TAG_W-1:0]  tag_in_i           = '0;
  logic              out_valid_o;
  logic              out_stall_i        = 1'b0;
  logic [1:0]        status_o;
  logic              replaced_o;
  logic [CODE_W-1:0] code_out_o;
  logic [TAG_W-1:0]  tag_out_o;
  logic              tag_valid_o;

  // mirror of the block's table and mode register
  logic [ENTRY_W-1:0] fold_table [CODE_SPACE];
  logic               pass_through_mode = 1'b1;
  res_t               fold_results_q [$];

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned win_base   = 0;
  rx_mode_e    rx_mode    = RX_FREE;
  int unsigned rx_left    = 0;

  char_fold_map_table_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_pass_thru_i    (cfg_pass_thru_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .src_code_i         (src_code_i),
    .src_last_i         (src_last_i),
    .dest_code_i        (dest_code_i),
    .dest_last_i        (dest_last_i),
    .tag_in_i           (tag_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .replaced_o         (replaced_o),
    .code_out_o         (code_out_o),
    .tag_out_o          (tag_out_o),
    .tag_valid_o        (tag_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic store_entry(int unsigned src, logic [CODE_W-1:0] code,
                                       logic [TAG_W-1:0] tag);
    logic [ENTRY_W-1:0] was;
    if (src >= CODE_SPACE) return 1'b0;
    was = fold_table[src];
    fold_table[src] = {tag, code};
    return was != '0;
  endfunction

  function automatic res_t predict_fold(fold_req_t rq);
    res_t               r;
    logic               skip;
    logic [ENTRY_W-1:0] e;
    int unsigned        k;
    r = '0;
    r.status = ST_OK;
    skip = pass_through_mode && (rq.tag_in == '0);
    case (rq.command)
      CMD_MAP: r.replaced = store_entry(rq.src_code, rq.dest_code, rq.tag_in);
      CMD_RANGE: begin
        if (rq.src_code >= rq.src_last || rq.dest_code >= rq.dest_last) begin
          r.status = ST_ORDER;
        end else if ((rq.src_last - rq.src_code) != (rq.dest_last - rq.dest_code)) begin
          r.status = ST_LEN;
        end else begin
          for (k = rq.src_code; k <= rq.src_last; k++)
            r.replaced |= store_entry(k, rq.dest_code + CODE_W'(k - rq.src_code), rq.tag_in);
        end
      end
      CMD_PASS: begin
        if (skip) r.status = ST_SKIP;
        else r.replaced = store_entry(rq.src_code, rq.src_code, rq.tag_in);
      end
      CMD_RANGE_PASS: begin
        // order error wins over the skip
        if (rq.src_code >= rq.src_last) begin
          r.status = ST_ORDER;
        end else if (skip) begin
          r.status = ST_SKIP;
        end else begin
          for (k = rq.src_code; k <= rq.src_last; k++)
            r.replaced |= store_entry(k, CODE_W'(k), rq.tag_in);
        end
      end
      CMD_TRANSFORM: begin
        e = (rq.src_code < CODE_SPACE) ? fold_table[rq.src_code] : '0;
        if (e != '0) begin
          r.code      = e[CODE_W-1:0];
          r.tag       = e[ENTRY_W-1:CODE_W];
          r.tag_valid = 1'b1;
        end else begin
          r.code = pass_through_mode ? rq.src_code : '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void flag_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (fold_results_q.size() == 0) begin
        fail_count++;
        $error("result beat with no pending request");
      end else begin
        want = fold_results_q.pop_front();
        if (status_o !== want.status) flag_field("status", want.status, status_o);
        if (replaced_o !== want.replaced) flag_field("replaced", want.replaced, replaced_o);
        if (code_out_o !== want.code) flag_field("code_out", want.code, code_out_o);
        if (tag_out_o !== want.tag) flag_field("tag_out", want.tag, tag_out_o);
        if (tag_valid_o !== want.tag_valid)
          flag_field("tag_valid", want.tag_valid, tag_valid_o);
      end
    end
  end

  // receiver backpressure, independent of the sender
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:     out_stall_i <= 1'b0;
      RX_LIGHT:    out_stall_i <= ($urandom_range(0, 9) < 3);
      RX_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 8);
      RX_PERIODIC: out_stall_i <= (rx_left % 4 == 0);
      default:     out_stall_i <= 1'b0;
    endcase
  end

  // ------------------------------------------------------------------ driving

  task automatic send_item(fold_req_t rq);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    command_i   <= rq.command;
    src_code_i  <= rq.src_code;
    src_last_i  <= rq.src_last;
    dest_code_i <= rq.dest_code;
    dest_last_i <= rq.dest_last;
    tag_in_i    <= rq.tag_in;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    fold_results_q.insert(fold_results_q.size(), predict_fold(rq));
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic issue_fold(logic [2:0] cmd, logic [CODE_W-1:0] src,
                            logic [CODE_W-1:0] src_last, logic [CODE_W-1:0] dst,
                            logic [CODE_W-1:0] dst_last, logic [TAG_W-1:0] tag);
    fold_req_t rq;
    rq.command   = cmd;
    rq.src_code  = src;
    rq.src_last  = src_last;
    rq.dest_code = dst;
    rq.dest_last = dst_last;
    rq.tag_in    = tag;
    send_item(rq);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (fold_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_pass_mode(logic mode);
    wait_drained();
    cfg_valid_i     <= 1'b1;
    cfg_pass_thru_i <= mode;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i       <= 1'b0;
    pass_through_mode = mode;
  endtask

  // ---------------------------------------------------------- random traffic

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 3) != 0) return CODE_W'(win_base + $urandom_range(0, WINDOW_SPAN - 1));
    return rnd16();
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 20) return '1;
    return rnd16();
  endfunction

  // mostly short walks, a few long ones
  function automatic int unsigned pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 15);
    if (r < 99) return $urandom_range(16, 255);
    return $urandom_range(256, 4095);
  endfunction

  function automatic fold_req_t random_fold_req();
    fold_req_t   rq;
    int unsigned r, span, lo, dlo;
    r            = $urandom_range(0, 99);
    rq.command   = CMD_TRANSFORM;
    rq.src_code  = pick_code();
    rq.src_last  = rnd16();
    rq.dest_code = pick_code();
    rq.dest_last = rnd16();
    rq.tag_in    = pick_tag();
    span = pick_span();
    lo   = rq.src_code;
    dlo  = rq.dest_code;
    if (lo + span > CODE_MAX) lo = CODE_MAX - span;
    if (dlo + span > CODE_MAX) dlo = CODE_MAX - span;
    if (r < 40) begin
      rq.command = CMD_TRANSFORM;
    end else if (r < 58) begin
      rq.command = CMD_MAP;
      if ($urandom_range(0, 29) == 0) rq.dest_code = '0;
    end else if (r < 72) begin
      rq.command = CMD_RANGE;
      // most ranges well formed; the rest keep random bounds
      if ($urandom_range(0, 6) != 0) begin
        rq.src_code  = CODE_W'(lo);
        rq.src_last  = CODE_W'(lo + span);
        rq.dest_code = CODE_W'(dlo);
        rq.dest_last = CODE_W'(dlo + span);
        if ($urandom_range(0, 9) == 0) rq.dest_last = CODE_W'(dlo + span + 1);
      end
    end else if (r < 82) begin
      rq.command = CMD_PASS;
    end else if (r < 96) begin
      rq.command = CMD_RANGE_PASS;
      if ($urandom_range(0, 6) != 0) begin
        rq.src_code = CODE_W'(lo);
        rq.src_last = CODE_W'(lo + span);
      end
    end else begin
      rq.command  = 3'(CMD_TRANSFORM) + 3'($urandom_range(1, 3));
      rq.src_code = rnd16();
    end
    return rq;
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_after_reset();
    issue_fold(CMD_TRANSFORM, '0, rnd16(), rnd16(), rnd16(), rnd16());
    issue_fold(CMD_TRANSFORM, CODE_MAX, rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_single_map();
    issue_fold(CMD_MAP, 16'h0041, rnd16(), 16'h0061, rnd16(), '1);
    issue_fold(CMD_TRANSFORM, 16'h0041, rnd16(), rnd16(), rnd16(), rnd16());
    issue_fold(CMD_MAP, 16'h0041, rnd16(), CODE_MAX, rnd16(), 16'h0001);
    // code 0 with tag 0 stores an empty entry
    issue_fold(CMD_MAP, 16'h0041, rnd16(), '0, rnd16(), '0);
    issue_fold(CMD_TRANSFORM, 16'h0041, rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_range_checks();
    issue_fold(CMD_RANGE, 16'h0010, 16'h0010, 16'h0030, 16'h0040, 16'h0101);
    issue_fold(CMD_RANGE, 16'h0010, 16'h0020, 16'h0030, 16'h0030, 16'h0101);
    issue_fold(CMD_RANGE, 16'h0010, 16'h0020, 16'h0030, 16'h0035, 16'h0101);
    issue_fold(CMD_RANGE_PASS, 16'h0305, 16'h0300, rnd16(), rnd16(), '0);
  endtask

  task automatic test_range_map();
    issue_fold(CMD_RANGE, 16'h0100, 16'h010F, 16'h0200, 16'h020F, 16'h1234);
    issue_fold(CMD_TRANSFORM, 16'h010F, rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_pass_map();
    issue_fold(CMD_PASS, 16'h0300, rnd16(), rnd16(), rnd16(), '0);
    issue_fold(CMD_RANGE_PASS, 16'h0300, 16'h0301, rnd16(), rnd16(), '0);
    issue_fold(CMD_PASS, 16'h0300, rnd16(), rnd16(), rnd16(), 16'hABCD);
    issue_fold(CMD_RANGE_PASS, 16'h02FF, 16'h0310, rnd16(), rnd16(), 16'h5555);
  endtask

  task automatic test_unknown_command();
    for (int k = 1; k <= 3; k++)
      issue_fold(3'(CMD_TRANSFORM) + 3'(k), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_pass_mode_off();
    set_pass_mode(1'b0);
    issue_fold(CMD_TRANSFORM, 16'h0400, rnd16(), rnd16(), rnd16(), rnd16());
    issue_fold(CMD_PASS, 16'h0401, rnd16(), rnd16(), rnd16(), '0);
    issue_fold(CMD_RANGE_PASS, 16'h0402, 16'h0403, rnd16(), rnd16(), '0);
    // whole code space both ways; the second walk leaves every code mapped to
    // itself with a zero tag, so only entry 0 ends up empty
    issue_fold(CMD_RANGE, '0, CODE_MAX, '0, CODE_MAX, '1);
    issue_fold(CMD_TRANSFORM, CODE_MAX, rnd16(), rnd16(), rnd16(), rnd16());
    issue_fold(CMD_RANGE_PASS, '0, CODE_MAX, rnd16(), rnd16(), '0);
    issue_fold(CMD_TRANSFORM, 16'h0041, rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      set_pass_mode(~p[0]);
      case (p % 3)
        0:       win_base = $urandom_range(0, CODE_MAX - WINDOW_SPAN + 1);
        1:       win_base = 0;
        default: win_base = CODE_MAX - WINDOW_SPAN + 1;
      endcase
      repeat (PHASE_ITEMS) send_item(random_fold_req());
    end
  endtask

  initial begin
    for (int k = 0; k < CODE_SPACE; k++) fold_table[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_single_map();
    test_range_checks();
    test_range_map();
    test_pass_map();
    test_unknown_command();
    test_pass_mode_off();
    test_random_traffic();

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && fold_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
